[rtl/crs_pkg.sv]
package crs_pkg;

  localparam int unsigned CRS_FRAGMENTS = 16;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PLEN_W        = 6;
  localparam int unsigned MAX_PLEN      = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SUB   = 2'd1,
    OP_FLUSH = 2'd2
  } crs_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FLUSH
  } crs_state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_len;
  } crs_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] range_begin;
    logic [ADDR_W-1:0] range_end;
    logic              last;
    logic              empty_res;
    logic              overflow;
  } crs_out_t;

  // One fragment as it is held in a cell and handed between cells.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
  } crs_frag_t;

  // Commands broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic load;
    logic sub;
    logic insert;
    logic insert_right;
    logic insert_left;
    logic rotate;
  } crs_ctrl_t;

endpackage

[rtl/crs_cell.sv]
module crs_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  crs_pkg::crs_ctrl_t            ctrl_i,
  input  logic                          head_i,
  input  logic [crs_pkg::ADDR_W-1:0]    lo_i,
  input  logic [crs_pkg::ADDR_W-1:0]    hi_i,
  input  logic [crs_pkg::ADDR_W-1:0]    lo_m1_i,
  input  logic [crs_pkg::ADDR_W-1:0]    hi_p1_i,
  input  logic [crs_pkg::ADDR_W-1:0]    up_lo_i,
  input  crs_pkg::crs_frag_t            left_i,
  input  crs_pkg::crs_frag_t            right_i,
  input  logic                          chain_r_i,
  input  logic                          chain_l_i,
  output crs_pkg::crs_frag_t            frag_o,
  output crs_pkg::crs_frag_t            hand_o,
  output logic                          chain_r_o,
  output logic                          chain_l_o
);
  import crs_pkg::*;

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] lo_q, lo_d;
  logic [ADDR_W-1:0] hi_q, hi_d;
  logic              split_q, split_d;
  logic [ADDR_W-1:0] spill_q, spill_d;
  logic              hit, keep_lo, keep_hi;
  crs_frag_t         frag_d;

  assign frag_o = '{valid: valid_q, lo: lo_q, hi: hi_q};

  // A cell that was split hands its upper piece to the right; all others hand their content.
  assign hand_o = split_q ? crs_frag_t'{valid: 1'b1, lo: up_lo_i, hi: spill_q} : frag_o;

  // The insert chains start at the split cell and run through occupied cells until a hole.
  assign chain_r_o = split_q | (chain_r_i & valid_q);
  assign chain_l_o = split_q | (chain_l_i & valid_q);

  always_comb begin
    hit     = valid_q && !(lo_i > hi_q) && !(hi_i < lo_q);
    keep_lo = lo_q < lo_i;
    keep_hi = hi_q > hi_i;
    frag_d  = frag_o;
    split_d = split_q;
    spill_d = spill_q;
    if (ctrl_i.load) begin
      frag_d  = '{valid: head_i, lo: lo_i, hi: hi_i};
      split_d = 1'b0;
    end else if (ctrl_i.sub) begin
      if (hit) begin
        if (!keep_lo && !keep_hi) begin
          frag_d.valid = 1'b0;
        end else begin
          if (keep_lo) begin
            frag_d.hi = lo_m1_i;
          end
          if (keep_hi && !keep_lo) begin
            frag_d.lo = hi_p1_i;
          end
          if (keep_lo && keep_hi) begin
            split_d = 1'b1;
            spill_d = hi_q;
          end
        end
      end
    end else if (ctrl_i.insert) begin
      split_d = 1'b0;
      if (ctrl_i.insert_right && chain_r_i) begin
        frag_d = left_i;
      end else if (ctrl_i.insert_left && chain_l_i) begin
        frag_d = right_i;
      end else if (ctrl_i.insert_left && split_q) begin
        // The lower piece moved left, so this cell takes the upper one.
        frag_d = '{valid: 1'b1, lo: up_lo_i, hi: spill_q};
      end
    end else if (ctrl_i.rotate) begin
      frag_d = right_i;
    end
    valid_d = frag_d.valid;
    lo_d    = frag_d.lo;
    hi_d    = frag_d.hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      split_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      split_q <= split_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    spill_q <= spill_d;
  end

endmodule

[rtl/cidr_range_subtraction.sv]
// Channel | Direction | Handshake                    | Beat
// input   | in        | in_valid_i / in_stall_o      | in_data_i  (op, address, prefix_len)
// output  | out       | out_valid_o / out_stall_i    | out_data_o (range, last, empty, overflow)
//
// A subtract first has every cell trim its fragment in the accept cycle, then the upper piece
// of a split ripples through the cell chain to a hole. A flush is made of the accept cycle,
// one rotation step of the chain per cell and the closing beat, and it holds while a
// waiting output beat is stalled.
// Reset clears the valid bit of every cell at once; no clearing pass follows.
module cidr_range_subtraction #(
  parameter int unsigned FRAGMENTS = crs_pkg::CRS_FRAGMENTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  crs_pkg::crs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crs_pkg::crs_out_t out_data_o
);
  import crs_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAGMENTS + 1);

  crs_state_e        state_q, state_d;
  crs_ctrl_t         ctrl;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              lost_q, lost_d;
  logic              pend_valid_q, pend_valid_d;
  logic [ADDR_W-1:0] pend_lo_q, pend_lo_d;
  logic [ADDR_W-1:0] pend_hi_q, pend_hi_d;
  logic [ADDR_W-1:0] up_lo_q, up_lo_d;
  logic              out_valid_q, out_valid_d;
  crs_out_t          out_data_q, out_data_d;

  logic              accept, out_free;
  logic [PLEN_W-1:0] plen;
  logic [ADDR_W-1:0] host, lo, hi, lo_m1, hi_p1;

  crs_frag_t         frag [FRAGMENTS];
  crs_frag_t         hand [FRAGMENTS];
  logic [FRAGMENTS:0] chain_r, chain_l;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Prefix lengths above the address width select a single address.
  always_comb begin
    plen  = (in_data_i.prefix_len > PLEN_W'(MAX_PLEN)) ? PLEN_W'(MAX_PLEN)
                                                        : in_data_i.prefix_len;
    host  = (plen == PLEN_W'(MAX_PLEN)) ? '0 : ({ADDR_W{1'b1}} >> plen);
    lo    = in_data_i.address & ~host;
    hi    = lo | host;
    lo_m1 = lo - ADDR_W'(1);
    hi_p1 = hi + ADDR_W'(1);
  end

  assign chain_r[0]         = 1'b0;
  assign chain_l[FRAGMENTS] = 1'b0;

  for (genvar k = 0; k < FRAGMENTS; k++) begin : g_cell
    crs_frag_t left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = hand[k-1];
    end
    if (k == FRAGMENTS - 1) begin : g_wrap
      assign right_w = frag[0];
    end else begin : g_inner_r
      assign right_w = frag[k+1];
    end

    crs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .head_i    (k == 0),
      .lo_i      (lo),
      .hi_i      (hi),
      .lo_m1_i   (lo_m1),
      .hi_p1_i   (hi_p1),
      .up_lo_i   (up_lo_q),
      .left_i    (left_w),
      .right_i   (right_w),
      .chain_r_i (chain_r[k]),
      .chain_l_i (chain_l[k+1]),
      .frag_o    (frag[k]),
      .hand_o    (hand[k]),
      .chain_r_o (chain_r[k+1]),
      .chain_l_o (chain_l[k])
    );
  end

  always_comb begin
    state_d      = state_q;
    ctrl         = '0;
    cnt_d        = cnt_q;
    lost_d       = lost_q;
    pend_valid_d = pend_valid_q;
    pend_lo_d    = pend_lo_q;
    pend_hi_d    = pend_hi_q;
    up_lo_d      = up_lo_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.op)
            OP_LOAD: begin
              ctrl.load = 1'b1;
              lost_d    = 1'b0;
            end
            OP_SUB: begin
              ctrl.sub = 1'b1;
              up_lo_d  = hi_p1;
              state_d  = ST_INSERT;
            end
            OP_FLUSH: begin
              cnt_d        = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INSERT: begin
        // Shift right into the first hole above the split, else left into one below it.
        ctrl.insert       = 1'b1;
        ctrl.insert_right = !chain_r[FRAGMENTS];
        ctrl.insert_left  = chain_r[FRAGMENTS] && !chain_l[0];
        if (chain_r[FRAGMENTS] && chain_l[0]) begin
          lost_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (cnt_q == CNT_W'(FRAGMENTS)) begin
            out_valid_d  = 1'b1;
            out_data_d   = pend_valid_q
                ? crs_out_t'{range_begin: pend_lo_q, range_end: pend_hi_q, last: 1'b1,
                             empty_res: 1'b0, overflow: lost_q}
                : crs_out_t'{range_begin: '0, range_end: '0, last: 1'b1,
                             empty_res: 1'b1, overflow: lost_q};
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end else begin
            // Each fragment is held back until the next one is found, so that the final one can carry last.
            ctrl.rotate = 1'b1;
            cnt_d       = cnt_q + CNT_W'(1);
            if (frag[0].valid) begin
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_data_d  = '{range_begin: pend_lo_q, range_end: pend_hi_q, last: 1'b0,
                                empty_res: 1'b0, overflow: lost_q};
              end
              pend_valid_d = 1'b1;
              pend_lo_d    = frag[0].lo;
              pend_hi_d    = frag[0].hi;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      lost_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      lost_q       <= lost_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_lo_q  <= pend_lo_d;
    pend_hi_q  <= pend_hi_d;
    up_lo_q    <= up_lo_d;
    out_data_q <= out_data_d;
  end

`ifndef ASSERT_OFF
  a_insert_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INSERT |=> state_q == ST_IDLE)
    else $error("insert step did not return to idle");

  a_sub_enters_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.op == OP_SUB |=> state_q == ST_INSERT)
    else $error("subtract did not start the insert step");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> cnt_q <= CNT_W'(FRAGMENTS))
    else $error("flush step count ran past the chain length");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_res |-> out_data_o.last)
    else $error("empty result not marked last");

  a_pend_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> state_q == ST_FLUSH)
    else $error("held fragment outside a flush");
`endif

endmodule
